[rtl/core/mmfe_pkg.sv]
`default_nettype none
package mmfe_pkg;

	localparam int unsigned NWHEEL    = 4;
	localparam int unsigned VEL_W     = 10;
	localparam int unsigned MIX_W     = 12;
	localparam int unsigned MAG_W     = 11;
	localparam int unsigned LIM_W     = 8;
	localparam int unsigned PROD_W    = MAG_W + LIM_W;
	localparam int unsigned QUO_W     = 12;
	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned DIV_CYC   = QUO_W / 2;
	localparam int unsigned DCNT_W    = $clog2(DIV_CYC);
	localparam int unsigned FRAME_LEN = 8;
	localparam int unsigned IDX_W     = $clog2(FRAME_LEN);

	localparam logic [LIM_W-1:0]  SPEED_LIMIT_RST = 8'd70;
	localparam logic [BYTE_W-1:0] HEAD0 = 8'hA5;
	localparam logic [BYTE_W-1:0] HEAD1 = 8'h5A;
	localparam logic [BYTE_W-1:0] TAIL0 = 8'hD5;
	localparam logic [BYTE_W-1:0] TAIL1 = 8'h5D;

	// byte slots of the frame
	localparam logic [IDX_W-1:0] SLOT_HEAD0 = 3'd0;
	localparam logic [IDX_W-1:0] SLOT_HEAD1 = 3'd1;
	localparam logic [IDX_W-1:0] SLOT_W2    = 3'd2;
	localparam logic [IDX_W-1:0] SLOT_W3    = 3'd3;
	localparam logic [IDX_W-1:0] SLOT_W1    = 3'd4;
	localparam logic [IDX_W-1:0] SLOT_W4    = 3'd5;
	localparam logic [IDX_W-1:0] SLOT_TAIL0 = 3'd6;
	localparam logic [IDX_W-1:0] SLOT_TAIL1 = 3'd7;

	typedef struct packed {
		logic              neg;
		logic [PROD_W-1:0] prod;
		logic [BYTE_W-1:0] raw;
	} lane_t;

	typedef struct packed {
		lane_t [NWHEEL-1:0] lane;
		logic [MAG_W-1:0]   divisor;
		logic               scale;
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} q_head_t;

endpackage
`default_nettype wire

[rtl/core/mmfe_front.sv]
`default_nettype none
module mmfe_front #(
	parameter int unsigned QDEPTH = 4,
	localparam int unsigned CntW = $clog2(QDEPTH + 1)
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic signed [mmfe_pkg::VEL_W-1:0]    vel_x,
	input  logic signed [mmfe_pkg::VEL_W-1:0]    vel_y,
	input  logic signed [mmfe_pkg::VEL_W-1:0]    vel_turn,
	input  logic [mmfe_pkg::LIM_W-1:0]           limit,
	input  logic [CntW-1:0]                      q_count,
	output logic                                 push,
	output mmfe_pkg::cmd_t                       push_cmd
);
	import mmfe_pkg::*;

	logic                     valid_s1;
	logic signed [VEL_W-1:0]  x_s1, y_s1, z_s1;
	logic                     valid_s2;
	logic signed [MIX_W-1:0]  mix_s2 [NWHEEL];
	logic signed [MIX_W-1:0]  xe, ye, ze;
	logic signed [MIX_W-1:0]  m01, m23, mx;
	logic [MAG_W-1:0]         mag [NWHEEL];
	logic [CntW:0]            inflight;

	assign inflight = (CntW + 1)'(q_count) + (CntW + 1)'(valid_s1) + (CntW + 1)'(valid_s2);
	assign busy = inflight >= (CntW + 1)'(QDEPTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			x_s1 <= vel_x;
			y_s1 <= vel_y;
			z_s1 <= vel_turn;
		end
	end

	assign xe = MIX_W'(x_s1);
	assign ye = MIX_W'(y_s1);
	assign ze = MIX_W'(z_s1);

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			mix_s2[0] <= ye - xe + ze;
			mix_s2[1] <= ye + xe - ze;
			mix_s2[2] <= ye - xe - ze;
			mix_s2[3] <= ye + xe + ze;
		end
	end

	assign m01 = (mix_s2[0] < mix_s2[1]) ? mix_s2[1] : mix_s2[0];
	assign m23 = (mix_s2[2] < mix_s2[3]) ? mix_s2[3] : mix_s2[2];
	assign mx  = (m01 < m23) ? m23 : m01;

	always_comb begin
		for (int i = 0; i < NWHEEL; i++) begin
			mag[i] = mix_s2[i][MIX_W-1] ? MAG_W'(-mix_s2[i]) : MAG_W'(mix_s2[i]);
			push_cmd.lane[i].neg  = mix_s2[i][MIX_W-1];
			push_cmd.lane[i].prod = PROD_W'(mag[i]) * PROD_W'(limit);
			push_cmd.lane[i].raw  = mix_s2[i][BYTE_W-1:0];
		end
		push_cmd.divisor = mx[MAG_W-1:0];
		push_cmd.scale   = mx > $signed({{(MIX_W - LIM_W){1'b0}}, limit});
	end

	assign push = valid_s2;

endmodule
`default_nettype wire

[rtl/core/mmfe_queue.sv]
`default_nettype none
module mmfe_queue #(
	parameter int unsigned QDEPTH = 4,
	localparam int unsigned CntW = $clog2(QDEPTH + 1),
	localparam int unsigned PtrW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  mmfe_pkg::cmd_t       push_cmd,
	input  logic                 pop,
	output mmfe_pkg::q_head_t    head,
	output logic [CntW-1:0]      count
);
	import mmfe_pkg::*;

	cmd_t            ent_q [QDEPTH];
	logic [PtrW-1:0] wptr_q, rptr_q;
	logic [CntW-1:0] cnt_q;

	function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
		return (p == PtrW'(QDEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) wptr_q <= ptr_inc(wptr_q);
			if (pop) rptr_q <= ptr_inc(rptr_q);
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) ent_q[wptr_q] <= push_cmd;
	end

	assign head.valid = cnt_q != '0;
	assign head.cmd   = ent_q[rptr_q];
	assign count      = cnt_q;

endmodule
`default_nettype wire

[rtl/core/mmfe_back.sv]
`default_nettype none
module mmfe_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mmfe_pkg::q_head_t             head,
	output logic                          pop,
	output logic                          strobe,
	output logic [mmfe_pkg::BYTE_W-1:0]   frame_byte,
	output logic                          last_byte
);
	import mmfe_pkg::*;

	typedef enum logic [2:0] {
		DIV_IDLE = 3'b001,
		DIV_RUN  = 3'b010,
		DIV_DONE = 3'b100
	} div_state_t;

	div_state_t        state_q;
	logic [DCNT_W-1:0] cnt_q;
	logic [MAG_W-1:0]  rem_q [NWHEEL];
	logic [QUO_W-1:0]  nlo_q [NWHEEL];
	logic [QUO_W-1:0]  quo_q [NWHEEL];
	logic              neg_q [NWHEEL];
	logic [BYTE_W-1:0] raw_q [NWHEEL];
	logic [MAG_W-1:0]  dvs_q;
	logic              scale_q;

	logic [MAG_W:0]    st_a [NWHEEL];
	logic [MAG_W:0]    st_b [NWHEEL];
	logic [BYTE_W-1:0] res  [NWHEEL];

	logic              active_q;
	logic [IDX_W-1:0]  idx_q;
	logic [BYTE_W-1:0] wb_q [NWHEEL];
	logic              emit_free, handoff;

	// one restoring step: {quotient bit, new remainder}
	function automatic logic [MAG_W:0] div_step(input logic [MAG_W-1:0] rem,
		input logic nbit, input logic [MAG_W-1:0] d);
		logic [MAG_W:0] t;
		t = {rem, nbit};
		if (t >= {1'b0, d}) return {1'b1, MAG_W'(t - {1'b0, d})};
		else return {1'b0, t[MAG_W-1:0]};
	endfunction

	assign emit_free = !active_q || (idx_q == SLOT_TAIL1);
	assign handoff   = (state_q == DIV_DONE) && emit_free;
	assign pop       = head.valid && ((state_q == DIV_IDLE) || handoff);

	always_comb begin
		for (int i = 0; i < NWHEEL; i++) begin
			st_a[i] = div_step(rem_q[i], nlo_q[i][QUO_W-1], dvs_q);
			st_b[i] = div_step(st_a[i][MAG_W-1:0], nlo_q[i][QUO_W-2], dvs_q);
			if (!scale_q) res[i] = raw_q[i];
			else if (neg_q[i]) res[i] = -quo_q[i][BYTE_W-1:0];
			else res[i] = quo_q[i][BYTE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DIV_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				DIV_IDLE: begin
					if (pop) begin
						state_q <= DIV_RUN;
						cnt_q   <= '0;
					end
				end
				DIV_RUN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == DCNT_W'(DIV_CYC - 1)) state_q <= DIV_DONE;
				end
				DIV_DONE: begin
					if (handoff) begin
						state_q <= pop ? DIV_RUN : DIV_IDLE;
						cnt_q   <= '0;
					end
				end
				default: state_q <= DIV_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			for (int i = 0; i < NWHEEL; i++) begin
				rem_q[i] <= MAG_W'(head.cmd.lane[i].prod[PROD_W-1:QUO_W]);
				nlo_q[i] <= head.cmd.lane[i].prod[QUO_W-1:0];
				quo_q[i] <= '0;
				neg_q[i] <= head.cmd.lane[i].neg;
				raw_q[i] <= head.cmd.lane[i].raw;
			end
			dvs_q   <= head.cmd.divisor;
			scale_q <= head.cmd.scale;
		end else if (state_q == DIV_RUN) begin
			for (int i = 0; i < NWHEEL; i++) begin
				rem_q[i] <= st_b[i][MAG_W-1:0];
				nlo_q[i] <= {nlo_q[i][QUO_W-3:0], 2'b00};
				quo_q[i] <= {quo_q[i][QUO_W-3:0], st_a[i][MAG_W], st_b[i][MAG_W]};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			idx_q    <= '0;
		end else if (handoff) begin
			active_q <= 1'b1;
			idx_q    <= '0;
		end else if (active_q) begin
			if (idx_q == SLOT_TAIL1) active_q <= 1'b0;
			idx_q <= idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (handoff) begin
			for (int i = 0; i < NWHEEL; i++) wb_q[i] <= res[i];
		end
	end

	always_comb begin
		case (idx_q)
			SLOT_HEAD0: frame_byte = HEAD0;
			SLOT_HEAD1: frame_byte = HEAD1;
			SLOT_W2:    frame_byte = wb_q[1];
			SLOT_W3:    frame_byte = wb_q[2];
			SLOT_W1:    frame_byte = wb_q[0];
			SLOT_W4:    frame_byte = wb_q[3];
			SLOT_TAIL0: frame_byte = TAIL0;
			default:    frame_byte = TAIL1;
		endcase
	end

	assign strobe    = active_q;
	assign last_byte = active_q && (idx_q == SLOT_TAIL1);

endmodule
`default_nettype wire

[rtl/core/mecanum_mix_frame_encoder.sv]
`default_nettype none
// Mecanum wheel mixer and command frame encoder.
// Command channel: drive vel_x, vel_y, vel_turn with start; the word is
// taken at a rising edge where start is high and busy is low.
// Result channel: each frame byte is on frame_byte for one cycle with
// strobe high; last_byte marks the eighth byte. The receiver takes every
// byte as it comes and cannot stall the block.
// Frame: A5 5A w2 w3 w1 w4 D5 5D, wheel speeds as signed low bytes,
// rescaled by speed_limit/max when the largest speed exceeds speed_limit.
// Commands go out at the pace of the byte emitter; the 4-lane radix-4
// divider runs under the previous frame. Up to QDEPTH commands may be
// buffered; busy rises when mix pipe plus queue hold QDEPTH words.
// Config: cfg_data written at cfg_valid (cfg_ready always high); the
// user must write it only while idle, the block does not enforce this.
// Reset clears all words in flight, speed_limit returns to 70.
module mecanum_mix_frame_encoder #(
	parameter int unsigned QDEPTH = 4
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic signed [mmfe_pkg::VEL_W-1:0]    vel_x,
	input  logic signed [mmfe_pkg::VEL_W-1:0]    vel_y,
	input  logic signed [mmfe_pkg::VEL_W-1:0]    vel_turn,
	output logic                                 strobe,
	output logic [mmfe_pkg::BYTE_W-1:0]          frame_byte,
	output logic                                 last_byte,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [mmfe_pkg::LIM_W-1:0]           cfg_data
);
	import mmfe_pkg::*;

	localparam int unsigned CntW = $clog2(QDEPTH + 1);

	logic [LIM_W-1:0] limit_q;
	logic [CntW-1:0]  q_count;
	logic             push, pop;
	cmd_t             push_cmd;
	q_head_t          head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) limit_q <= SPEED_LIMIT_RST;
		else if (cfg_valid && cfg_ready) limit_q <= cfg_data;
	end

	mmfe_front #(.QDEPTH(QDEPTH)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.vel_x    (vel_x),
		.vel_y    (vel_y),
		.vel_turn (vel_turn),
		.limit    (limit_q),
		.q_count  (q_count),
		.push     (push),
		.push_cmd (push_cmd)
	);

	mmfe_queue #(.QDEPTH(QDEPTH)) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.count    (q_count)
	);

	mmfe_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.pop        (pop),
		.strobe     (strobe),
		.frame_byte (frame_byte),
		.last_byte  (last_byte)
	);

endmodule
`default_nettype wire

[dv/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;
	import mmfe_pkg::*;

	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              last;
	} fbyte_t;

	// directed row; lim < 0 keeps the current speed limit
	typedef struct {
		int          lim;
		int          x;
		int          y;
		int          z;
		bit          fixed;
		logic [31:0] wheels;
	} row_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     start = 1'b0;
	logic signed [VEL_W-1:0]  vel_x = '0;
	logic signed [VEL_W-1:0]  vel_y = '0;
	logic signed [VEL_W-1:0]  vel_turn = '0;
	logic                     cfg_valid = 1'b0;
	logic [LIM_W-1:0]         cfg_data = '0;
	logic                     busy;
	logic                     strobe;
	logic [BYTE_W-1:0]        frame_byte;
	logic                     last_byte;
	logic                     cfg_ready;

	fbyte_t pending_bytes [$];
	row_t   dir_rows [$];
	int     speed_lim = SPEED_LIMIT_RST;
	int     n_err = 0;

	mecanum_mix_frame_encoder u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.vel_x      (vel_x),
		.vel_y      (vel_y),
		.vel_turn   (vel_turn),
		.strobe     (strobe),
		.frame_byte (frame_byte),
		.last_byte  (last_byte),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#3_000_000;
		$display("Test completed with failures");
		$finish;
	end

	// wheel bytes {w2, w3, w1, w4} for one velocity word
	function automatic logic [31:0] mix_wheels(input logic signed [VEL_W-1:0] vx,
			input logic signed [VEL_W-1:0] vy, input logic signed [VEL_W-1:0] vz);
		int x, y, z, pk;
		int s [NWHEEL];
		x = vx;
		y = vy;
		z = vz;
		s[0] = y - x + z;
		s[1] = y + x - z;
		s[2] = y - x - z;
		s[3] = y + x + z;
		pk = s[0];
		for (int i = 1; i < NWHEEL; i++)
			if (s[i] > pk) pk = s[i];
		if (pk > speed_lim) begin
			for (int i = 0; i < NWHEEL; i++)
				s[i] = (s[i] * speed_lim) / pk;
		end
		return {s[1][7:0], s[2][7:0], s[0][7:0], s[3][7:0]};
	endfunction

	function automatic void push_frame(input logic [31:0] w);
		logic [BYTE_W-1:0] fr [FRAME_LEN];
		fr[SLOT_HEAD0] = HEAD0;
		fr[SLOT_HEAD1] = HEAD1;
		fr[SLOT_W2]    = w[31:24];
		fr[SLOT_W3]    = w[23:16];
		fr[SLOT_W1]    = w[15:8];
		fr[SLOT_W4]    = w[7:0];
		fr[SLOT_TAIL0] = TAIL0;
		fr[SLOT_TAIL1] = TAIL1;
		for (int i = 0; i < FRAME_LEN; i++)
			pending_bytes.push_back('{fr[i], i == FRAME_LEN - 1});
	endfunction

	function automatic logic signed [VEL_W-1:0] rand_vel(input bit wide);
		int v;
		if (wide) v = $urandom_range(0, 1023) - 512;
		else v = $urandom_range(0, 200) - 100;
		return v[VEL_W-1:0];
	endfunction

	task automatic add_row(input int lim, input int x, input int y, input int z,
			input bit fixed, input logic [31:0] w);
		row_t r;
		r.lim = lim;
		r.x = x;
		r.y = y;
		r.z = z;
		r.fixed = fixed;
		r.wheels = w;
		dir_rows.push_back(r);
	endtask

	// called at a rising edge; returns at the edge that takes the word
	task automatic send(input logic signed [VEL_W-1:0] vx, input logic signed [VEL_W-1:0] vy,
			input logic signed [VEL_W-1:0] vz, input logic [31:0] w);
		vel_x <= vx;
		vel_y <= vy;
		vel_turn <= vz;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		push_frame(w);
	endtask

	task automatic idle_gap(input int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic drain;
		start <= 1'b0;
		do @(posedge clk); while (pending_bytes.size() != 0);
	endtask

	task automatic write_limit(input logic [LIM_W-1:0] v);
		drain();
		cfg_data <= v;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		speed_lim = v;
	endtask

	always @(posedge clk) begin
		fbyte_t want;
		if (arst_n && strobe) begin
			if (pending_bytes.size() == 0) begin
				$display("%0t: unexpected byte, expected none, actual %h last %b",
					$time, frame_byte, last_byte);
				n_err++;
			end else begin
				want = pending_bytes.pop_front();
				if (frame_byte !== want.data) begin
					$display("%0t: frame_byte expected %h actual %h",
						$time, want.data, frame_byte);
					n_err++;
				end
				if (last_byte !== want.last) begin
					$display("%0t: last_byte expected %b actual %b",
						$time, want.last, last_byte);
					n_err++;
				end
			end
		end
	end

	initial begin
		logic signed [VEL_W-1:0] vx, vy, vz;
		logic [31:0] w;
		int lims [6];
		add_row(-1, 0, 0, 0, 1'b1, 32'h00000000);
		add_row(-1, 0, 511, 0, 1'b1, 32'h46464646);
		add_row(-1, 0, -512, 0, 1'b1, 32'h00000000);
		add_row(-1, -512, -512, -512, 1'b1, 32'hBA46BA2E);
		add_row(-1, 511, 511, 511, 1'b1, 32'h17E91746);
		add_row(-1, 10, 20, 5, 1'b1, 32'h19050F23);
		add_row(-1, 0, 70, 0, 1'b1, 32'h46464646);
		add_row(-1, 0, 71, 0, 1'b1, 32'h46464646);
		add_row(-1, 511, -512, 0, 1'b0, 32'h0);
		add_row(-1, -512, 511, 511, 1'b0, 32'h0);
		add_row(-1, 0, 0, -512, 1'b0, 32'h0);
		add_row(-1, 0, 0, 511, 1'b0, 32'h0);
		add_row(-1, -300, 0, 0, 1'b0, 32'h0);
		add_row(255, 511, 511, 0, 1'b1, 32'hFF0000FF);
		add_row(-1, -1, -1, -1, 1'b0, 32'h0);
		add_row(0, 0, 1, 0, 1'b1, 32'h00000000);
		add_row(-1, 0, -5, 0, 1'b1, 32'hFBFBFBFB);
		add_row(-1, 0, 0, 0, 1'b1, 32'h00000000);
		add_row(-1, 200, -100, 50, 1'b0, 32'h0);
		add_row(1, 3, 2, 1, 1'b1, 32'h00000001);
		add_row(70, 511, -512, 511, 1'b0, 32'h0);
		add_row(-1, -512, 511, -512, 1'b0, 32'h0);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].lim >= 0) write_limit(LIM_W'(dir_rows[i].lim));
			vx = VEL_W'(dir_rows[i].x);
			vy = VEL_W'(dir_rows[i].y);
			vz = VEL_W'(dir_rows[i].z);
			w = dir_rows[i].fixed ? dir_rows[i].wheels : mix_wheels(vx, vy, vz);
			send(vx, vy, vz, w);
			if ($urandom_range(0, 3) == 0) idle_gap($urandom_range(1, 9));
		end

		lims[0] = 255;
		lims[1] = 1;
		lims[2] = 0;
		lims[3] = $urandom_range(2, 254);
		lims[4] = $urandom_range(0, 255);
		lims[5] = SPEED_LIMIT_RST;
		for (int p = 0; p < 6; p++) begin
			write_limit(LIM_W'(lims[p]));
			for (int k = 0; k < 32; k++) begin
				if (p == 3 && k == 10) drain();
				vx = rand_vel(1'($urandom_range(0, 1)));
				vy = rand_vel(1'($urandom_range(0, 1)));
				vz = rand_vel(1'($urandom_range(0, 1)));
				send(vx, vy, vz, mix_wheels(vx, vy, vz));
				if (p < 5 && (k % 12) < 8 && $urandom_range(0, 2) == 0)
					idle_gap($urandom_range(1, 9));
			end
		end

		drain();
		repeat (20) @(posedge clk);
		if (n_err == 0) $display("Test completed successfully");
		else $display("Test completed with failures");
		$finish;
	end

endmodule

[filelist.f]
rtl/core/mmfe_pkg.sv
rtl/core/mmfe_front.sv
rtl/core/mmfe_queue.sv
rtl/core/mmfe_back.sv
rtl/core/mecanum_mix_frame_encoder.sv
dv/tb_top.sv
